// ===== design/sieve_endpoint_cache_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the key store checker.
// ----------------------------------------------------------------------------
`ifndef SIEVE_ENDPOINT_CACHE_ASSERT_SVH
`define SIEVE_ENDPOINT_CACHE_ASSERT_SVH

// An implication checked on every clock edge outside reset.
`define SEC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// A condition checked in the cycle after its trigger.
`define SEC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/sec_pkg.sv =====
// ----------------------------------------------------------------------------
// Key store package
// Shared types, widths and codes of the key store.
// ----------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

    localparam int CAPACITY  = 32;
    localparam int KEY_WIDTH = 32;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int CFG_W     = 6;

    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_HIT       = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_REPLACED  = 3'd2;
    localparam logic [2:0] ST_EVICTED   = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_NOT_FOUND = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [1:0]           mode;
        logic [KEY_WIDTH-1:0] key;
        logic                 terminal;
    } in_item_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [KEY_WIDTH-1:0] out_key;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic load;        // capture input item
        logic search;      // search for key, register result
        logic remove_hit;  // remove the found entry
        logic set_visit;   // mark the found entry visited
        logic clear_all;   // empty the store
        logic evict_step;  // one step of the hand
        logic insert;      // append the key as newest
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       terminal;
        logic       found;
        logic       full;
        logic       victim;  // the hand points at an unvisited entry
        logic       empty;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/sec_datapath.sv =====
// ----------------------------------------------------------------------------
// Key store datapath
// Key slots, visited bits, count, hand and the search and shift logic.
// ----------------------------------------------------------------------------
`default_nettype none

module sec_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire sec_pkg::in_item_t             in_item,
    input  wire logic [sec_pkg::CFG_W-1:0]     max_entries,
    input  wire sec_pkg::dp_cmd_t              cmd,
    output sec_pkg::dp_stat_t                  stat,
    output logic [sec_pkg::KEY_WIDTH-1:0]      key_out,
    output logic [sec_pkg::KEY_WIDTH-1:0]      victim_key
);

    localparam int N = sec_pkg::CAPACITY;
    localparam int IW = sec_pkg::IDX_W;
    localparam int CW = sec_pkg::CNT_W;

    logic [sec_pkg::KEY_WIDTH-1:0] slot_key_reg [N];
    logic [N-1:0]                  visited_reg;
    logic [CW-1:0]                 count_reg;
    logic [IW-1:0]                 hand_reg;
    logic                          hand_valid_reg;
    sec_pkg::in_item_t             item_reg;
    logic                          found_reg;
    logic [IW-1:0]                 pos_reg;

    logic [CW-1:0] limit;
    logic [N-1:0]  match;
    logic          found_c;
    logic [IW-1:0] pos_c;
    logic [IW-1:0] p_eff;
    logic [CW-1:0] p_ext;
    logic          shift_en;
    logic [IW-1:0] shift_at;

    always_comb begin
        if (max_entries == '0) begin
            limit = CW'(1);
        end else if (32'(max_entries) > N) begin
            limit = CW'(N);
        end else begin
            limit = CW'(max_entries);
        end
    end

    always_comb begin
        found_c = 1'b0;
        pos_c   = '0;
        for (int i = N - 1; i >= 0; i--) begin
            match[i] = (CW'(i) < count_reg) && (slot_key_reg[i] == item_reg.key);
            if (match[i]) begin
                found_c = 1'b1;
                pos_c   = IW'(i);
            end
        end
    end

    always_comb begin
        p_eff = hand_valid_reg ? hand_reg : '0;
        if (CW'(p_eff) >= count_reg) begin
            p_eff = '0;
        end
        p_ext = CW'(p_eff);
    end

    assign stat.mode     = item_reg.mode;
    assign stat.terminal = item_reg.terminal;
    assign stat.found    = found_reg;
    assign stat.full     = count_reg >= limit;
    assign stat.empty    = count_reg == '0;
    assign stat.victim   = !visited_reg[p_eff];
    assign key_out       = item_reg.key;
    assign victim_key    = slot_key_reg[p_eff];

    always_comb begin
        shift_en = 1'b0;
        shift_at = pos_reg;
        if (cmd.remove_hit) begin
            shift_en = 1'b1;
        end else if (cmd.evict_step && !visited_reg[p_eff] && count_reg != '0) begin
            shift_en = 1'b1;
            shift_at = p_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
        end
        if (cmd.search) begin
            found_reg <= found_c;
            pos_reg   <= pos_c;
        end
        for (int i = 0; i < N - 1; i++) begin
            if (shift_en && IW'(i) >= shift_at) begin
                slot_key_reg[i] <= slot_key_reg[i + 1];
            end
        end
        if (cmd.insert && count_reg < CW'(N)) begin
            slot_key_reg[count_reg[IW-1:0]] <= item_reg.key;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            visited_reg    <= '0;
            count_reg      <= '0;
            hand_reg       <= '0;
            hand_valid_reg <= 1'b0;
        end else if (cmd.clear_all) begin
            visited_reg    <= '0;
            count_reg      <= '0;
            hand_reg       <= '0;
            hand_valid_reg <= 1'b0;
        end else if (cmd.set_visit) begin
            visited_reg[pos_reg] <= 1'b1;
        end else if (cmd.remove_hit) begin
            for (int i = 0; i < N; i++) begin
                if (IW'(i) >= pos_reg) begin
                    visited_reg[i] <= (i < N - 1) ? visited_reg[(i + 1) % N] : 1'b0;
                end
            end
            count_reg <= count_reg - CW'(1);
            if (count_reg == CW'(1)) begin
                hand_valid_reg <= 1'b0;
                hand_reg       <= '0;
            end else if (hand_valid_reg) begin
                if (hand_reg > pos_reg) begin
                    hand_reg <= hand_reg - IW'(1);
                end else if (hand_reg == pos_reg && CW'(pos_reg) + CW'(1) == count_reg) begin
                    hand_valid_reg <= 1'b0;
                end
            end
        end else if (cmd.evict_step && count_reg != '0) begin
            if (visited_reg[p_eff]) begin
                visited_reg[p_eff] <= 1'b0;
                hand_valid_reg     <= 1'b1;
                hand_reg <= (p_ext + CW'(1) == count_reg) ? '0 : p_eff + IW'(1);
            end else begin
                for (int i = 0; i < N; i++) begin
                    if (IW'(i) >= p_eff) begin
                        visited_reg[i] <= (i < N - 1) ? visited_reg[(i + 1) % N] : 1'b0;
                    end
                end
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    hand_valid_reg <= 1'b0;
                    hand_reg       <= '0;
                end else begin
                    hand_valid_reg <= 1'b1;
                    hand_reg <= (p_ext + CW'(1) == count_reg) ? '0 : p_eff;
                end
            end
        end else if (cmd.insert && count_reg < CW'(N)) begin
            visited_reg[count_reg[IW-1:0]] <= 1'b0;
            count_reg <= count_reg + CW'(1);
        end
    end

endmodule

`default_nettype wire

// ===== design/sec_control.sv =====
// ----------------------------------------------------------------------------
// Key store controller
// Sequences search, removal, the hand walk and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sec_control (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output sec_pkg::out_item_t                 m_item,
    output sec_pkg::dp_cmd_t                   cmd,
    input  wire sec_pkg::dp_stat_t             stat,
    input  wire logic [sec_pkg::KEY_WIDTH-1:0] key_out,
    input  wire logic [sec_pkg::KEY_WIDTH-1:0] victim_key
);

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_DECIDE, S_EVICT, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    sec_pkg::out_item_t m_item_reg, m_item_next;
    logic               replace_reg, replace_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        replace_next = replace_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH: begin
                cmd.search = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (!m_valid_next) begin
                    state_next = S_IDLE;
                    case (stat.mode)
                        sec_pkg::MODE_CLEAR: begin
                            cmd.clear_all = 1'b1;
                            m_valid_next  = 1'b1;
                            m_item_next   = '{sec_pkg::ST_CLEARED, key_out, 1'b1};
                        end
                        sec_pkg::MODE_REMOVE: begin
                            cmd.remove_hit = stat.found;
                            m_valid_next   = 1'b1;
                            m_item_next    = '{stat.found ? sec_pkg::ST_REMOVED
                                                          : sec_pkg::ST_NOT_FOUND,
                                               key_out, 1'b1};
                        end
                        sec_pkg::MODE_LOOKUP: begin
                            if (stat.found && !stat.terminal) begin
                                cmd.set_visit = 1'b1;
                                m_valid_next  = 1'b1;
                                m_item_next   = '{sec_pkg::ST_HIT, key_out, 1'b1};
                            end else begin
                                cmd.remove_hit = stat.found;
                                replace_next   = stat.found;
                                state_next     = S_EVICT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_EVICT: begin
                if (!stat.full || stat.empty) begin
                    state_next = S_OUT;
                end else if (!stat.victim) begin
                    cmd.evict_step = 1'b1;
                end else if (!m_valid_next) begin
                    cmd.evict_step = 1'b1;
                    m_valid_next   = 1'b1;
                    m_item_next    = '{sec_pkg::ST_EVICTED, victim_key, 1'b0};
                end
            end
            S_OUT: begin
                if (!m_valid_next) begin
                    cmd.insert   = 1'b1;
                    m_valid_next = 1'b1;
                    m_item_next  = '{replace_reg ? sec_pkg::ST_REPLACED
                                                 : sec_pkg::ST_INSERTED,
                                     key_out, 1'b1};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            replace_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            replace_reg <= replace_next;
        end
        m_item_reg <= m_item_next;
    end

endmodule

`default_nettype wire

// ===== design/sieve_endpoint_cache.sv =====
// An accepted transaction passes S_SEARCH and S_DECIDE; a hit, remove or clear registers its
// result in S_DECIDE, an insert or replace passes S_EVICT and registers its result in S_OUT.
// A new transaction is accepted only in S_IDLE, after the last one is through; in S_EVICT
// the hand takes a step for each visited entry it passes and for each key it evicts.
// A result that waits for m_ready holds the controller until it is taken.
// Reset is synchronous, active low: the store empties, max_entries returns to 32.
// ----------------------------------------------------------------------------
// SIEVE key store top level
// Key store with SIEVE eviction, a controller and a datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sieve_endpoint_cache (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sec_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire sec_pkg::in_item_t             s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output sec_pkg::out_item_t                 m_item
);

    logic [sec_pkg::CFG_W-1:0]     max_entries_reg;
    sec_pkg::dp_cmd_t              cmd;
    sec_pkg::dp_stat_t             stat;
    logic [sec_pkg::KEY_WIDTH-1:0] key_out;
    logic [sec_pkg::KEY_WIDTH-1:0] victim_key;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_entries_reg <= sec_pkg::CFG_W'(32);
        end else if (cfg_we) begin
            max_entries_reg <= cfg_wdata;
        end
    end

    sec_control u_control (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_item,
        .cmd, .stat, .key_out, .victim_key
    );

    sec_datapath u_datapath (
        .aclk, .aresetn, .in_item(s_item), .max_entries(max_entries_reg),
        .cmd, .stat, .key_out, .victim_key
    );

endmodule

`default_nettype wire

// ===== design/sec_checker.sv =====
// ----------------------------------------------------------------------------
// Key store port checker
// Checks handshake and result ordering rules seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sieve_endpoint_cache_assert.svh"

module sec_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire sec_pkg::out_item_t m_item
);

    `SEC_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid && $stable(m_item))
    `SEC_ASSERT_IMPL(a_evict_not_last, m_valid && m_item.status == sec_pkg::ST_EVICTED, !m_item.last)
    `SEC_ASSERT_IMPL(a_other_last, m_valid && m_item.status != sec_pkg::ST_EVICTED, m_item.last)
    `SEC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

endmodule

bind sieve_endpoint_cache sec_checker u_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_item
);

`default_nettype wire

// ===== bench/sieve_endpoint_cache_tb.sv =====
// ----------------------------------------------------------------------------
// SIEVE key store testbench
// Drives lookups, terminal replacements, removals, clears, spare-mode items and
// limit writes with random gaps on both channels, predicts every result from a model
// of the store and its hand, and compares each result transaction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sieve_endpoint_cache_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int CAP = sec_pkg::CAPACITY;
    localparam int KW = sec_pkg::KEY_WIDTH;
    localparam int CW = sec_pkg::CFG_W;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    class key_store_scoreboard;
        logic [KW-1:0] keys[CAP];
        bit visited[CAP];
        int count;
        int hand;
        bit hand_on;
        int limit_reg;
        sec_pkg::out_item_t pending[$];
        int errors;

        function new();
            count = 0;
            hand = 0;
            hand_on = 0;
            limit_reg = 32;
            errors = 0;
        endfunction

        function int limit_eff();
            if (limit_reg < 1) return 1;
            if (limit_reg > CAP) return CAP;
            return limit_reg;
        endfunction

        function void drop_slot(int r);
            for (int i = r; i + 1 < count; i++) begin
                keys[i] = keys[i+1];
                visited[i] = visited[i+1];
            end
            count--;
            if (count == 0) begin
                hand_on = 0;
                hand = 0;
            end
        endfunction

        function int locate(logic [KW-1:0] k);
            for (int i = 0; i < count; i++)
                if (keys[i] == k) return i;
            return -1;
        endfunction

        function void push(logic [2:0] st, logic [KW-1:0] k, logic lst);
            sec_pkg::out_item_t r;
            r.status = st;
            r.out_key = k;
            r.last = lst;
            pending.insert(pending.size(), r);
        endfunction

        function void note_input(sec_pkg::in_item_t it);
            int pos;
            int p;
            logic [2:0] fin;
            fin = sec_pkg::ST_INSERTED;
            if (it.mode == sec_pkg::MODE_CLEAR) begin
                for (int i = 0; i < CAP; i++) visited[i] = 0;
                count = 0;
                hand = 0;
                hand_on = 0;
                push(sec_pkg::ST_CLEARED, it.key, 1'b1);
                return;
            end
            if (it.mode != sec_pkg::MODE_LOOKUP && it.mode != sec_pkg::MODE_REMOVE) return;
            pos = locate(it.key);
            if (it.mode == sec_pkg::MODE_REMOVE || (pos >= 0 && it.terminal)) begin
                if (pos < 0) begin
                    push(sec_pkg::ST_NOT_FOUND, it.key, 1'b1);
                    return;
                end
                if (hand_on) begin
                    if (hand > pos) hand--;
                    else if (hand == pos && pos + 1 == count) hand_on = 0;
                end
                drop_slot(pos);
                if (it.mode == sec_pkg::MODE_REMOVE) begin
                    push(sec_pkg::ST_REMOVED, it.key, 1'b1);
                    return;
                end
                fin = sec_pkg::ST_REPLACED;
            end else if (pos >= 0) begin
                visited[pos] = 1;
                push(sec_pkg::ST_HIT, it.key, 1'b1);
                return;
            end
            while (count >= limit_eff() && count > 0) begin
                p = hand_on ? hand : 0;
                if (p >= count) p = 0;
                while (visited[p]) begin
                    visited[p] = 0;
                    p = (p + 1 == count) ? 0 : p + 1;
                end
                push(sec_pkg::ST_EVICTED, keys[p], 1'b0);
                hand_on = 1;
                hand = (p + 1 == count) ? 0 : p;
                drop_slot(p);
            end
            if (count < CAP) begin
                keys[count] = it.key;
                visited[count] = 0;
                count++;
            end
            push(fin, it.key, 1'b1);
        endfunction

        function void check_result(sec_pkg::out_item_t got);
            sec_pkg::out_item_t exp;
            if (pending.size() == 0) begin
                $error("unexpected result: status %0d out_key %h", got.status, got.out_key);
                errors++;
                return;
            end
            exp = pending[0];
            pending.delete(0);
            if (got.status !== exp.status) begin
                $error("status: expected %0d, actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.out_key !== exp.out_key) begin
                $error("out_key: expected %h, actual %h", exp.out_key, got.out_key);
                errors++;
            end
            if (got.last !== exp.last) begin
                $error("last: expected %0d, actual %0d", exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_we = 0;
    logic [CW-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    sec_pkg::in_item_t s_item = '0;
    logic m_valid;
    logic m_ready = 0;
    sec_pkg::out_item_t m_item;

    key_store_scoreboard board = new();
    logic [KW-1:0] used_keys[$];
    int idle_cycles = 0;

    always #2 aclk = ~aclk;

    sieve_endpoint_cache uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always @(posedge aclk) begin
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready))) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** sieve_endpoint_cache: FAILED **");
            $finish;
        end
    end

    // The receiver draws a random stall before each result, and many of the draws are zero.
    initial begin : receiver
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8));
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk iff m_valid);
            board.check_result(m_item);
        end
    end

    task automatic send_item(logic [1:0] mode, logic [KW-1:0] key, logic term,
                             bit no_gap = 1'b0);
        sec_pkg::in_item_t it;
        int gap;
        gap = no_gap ? 0 : int'($urandom_range(0, 8));
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it.mode = mode;
        it.key = key;
        it.terminal = term;
        s_item <= it;
        s_valid <= 1'b1;
        @(posedge aclk iff s_ready);
        board.note_input(it);
        if (mode == sec_pkg::MODE_LOOKUP) used_keys.insert(used_keys.size(), key);
    endtask

    task automatic drain_out();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_limit(logic [CW-1:0] v);
        drain_out();
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        cfg_we <= 1'b0;
        board.limit_reg = int'(v);
    endtask

    function automatic logic [KW-1:0] pick_key();
        if (used_keys.size() != 0 && $urandom_range(0, 2) != 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        return {4'($urandom_range(0, 15)), 28'h0} | KW'($urandom_range(0, 47));
    endfunction

    task automatic random_phase(int n);
        int r;
        logic [1:0] md;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 70) md = sec_pkg::MODE_LOOKUP;
            else if (r < 88) md = sec_pkg::MODE_REMOVE;
            else if (r < 92) md = sec_pkg::MODE_CLEAR;
            else md = MODE_SPARE;
            send_item(md, (r % 17 == 0) ? KW'($urandom) : pick_key(),
                      $urandom_range(0, 3) == 0, (i % 20) < 5);
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send_item(sec_pkg::MODE_REMOVE, 32'h0, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h0, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 1'b1);
        send_item(sec_pkg::MODE_LOOKUP, 32'h0, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h0, 1'b1);
        send_item(sec_pkg::MODE_LOOKUP, 32'h5555_AAAA, 1'b0);
        send_item(sec_pkg::MODE_REMOVE, 32'h5555_AAAA, 1'b1);
        send_item(sec_pkg::MODE_REMOVE, 32'h1234_5678, 1'b0);
        send_item(MODE_SPARE, 32'hAAAA_5555, 1'b1);
        send_item(sec_pkg::MODE_CLEAR, 32'hDEAD_BEEF, 1'b1);
        write_limit(6'd0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h11, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h22, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h22, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h22, 1'b1);
        send_item(sec_pkg::MODE_REMOVE, 32'h22, 1'b0);
        write_limit(6'd3);
        for (int k = 1; k <= 3; k++) send_item(sec_pkg::MODE_LOOKUP, 32'h100 + k, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h101, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h103, 1'b0);
        send_item(sec_pkg::MODE_LOOKUP, 32'h104, 1'b0);
        send_item(sec_pkg::MODE_REMOVE, 32'h104, 1'b0);
        write_limit(6'd63);
        for (int k = 0; k < 34; k++)
            send_item(sec_pkg::MODE_LOOKUP, 32'h200 + k, 1'b0, 1'b1);
        for (int k = 0; k < 32; k += 2)
            send_item(sec_pkg::MODE_LOOKUP, 32'h202 + k, 1'b0, 1'b1);
        write_limit(6'd2);
        send_item(sec_pkg::MODE_LOOKUP, 32'hBEEF, 1'b0);
        used_keys.delete();
        random_phase(30);
        write_limit(6'd32);
        random_phase(30);
        drain_out();
        write_limit(6'd5);
        random_phase(25);
        write_limit(6'd1);
        random_phase(12);
        write_limit(6'd33);
        random_phase(10);
        drain_out();
        if (board.errors == 0) begin
            $display("** sieve_endpoint_cache: PASSED **");
        end else begin
            $display("** sieve_endpoint_cache: FAILED **");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/sec_pkg.sv
design/sec_datapath.sv
design/sec_control.sv
design/sieve_endpoint_cache.sv
design/sec_checker.sv
bench/sieve_endpoint_cache_tb.sv
